// ===== src/pckp_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pckp_pkg: shared types and constants
// Request and response payloads, key codes and the keypad layout table.
// ----------------------------------------------------------------------------
package pckp_pkg;

   localparam int unsigned EntryWidth = 30;
   localparam int unsigned CountWidth = 32;
   localparam int unsigned ReloadWidth = 5;
   localparam logic [ReloadWidth-1:0] LockoutReset = 5'd20;

   // Key codes: 0..9 are the digit itself
   localparam logic [3:0] KeyHash = 4'd10;
   localparam logic [3:0] KeyStar = 4'd11;
   localparam logic [3:0] KeyNone = 4'd15;

   // Last column index of the scan
   localparam logic [1:0] LastColumn = 2'd2;

   typedef logic [ReloadWidth-1:0] reload_type;

   typedef struct packed {
      logic       sensor_a;
      logic       sensor_b;
      logic [3:0] key_rows;
   } req_type;

   typedef struct packed {
      logic [2:0]                   column_drive;
      logic signed [CountWidth-1:0] occupancy;
      logic                         entry_mode;
      logic [EntryWidth-1:0]        entry_value;
      logic                         send_request;
   } rsp_type;

   // Decoded key from one scan step
   typedef struct packed {
      logic       hit;
      logic [3:0] code;
   } key_type;

   // 3x4 keypad layout by row and column
   function automatic logic [3:0] key_lookup(input logic [1:0] row, input logic [1:0] col);
      logic [3:0] code;
      code = KeyNone;
      case ({row, col})
         4'b00_00: code = 4'd1;
         4'b00_01: code = 4'd2;
         4'b00_10: code = 4'd3;
         4'b01_00: code = 4'd4;
         4'b01_01: code = 4'd5;
         4'b01_10: code = 4'd6;
         4'b10_00: code = 4'd7;
         4'b10_01: code = 4'd8;
         4'b10_10: code = 4'd9;
         4'b11_00: code = KeyHash;
         4'b11_01: code = 4'd0;
         4'b11_10: code = KeyStar;
         default: code = KeyNone;
      endcase
      return code;
   endfunction

endpackage
`default_nettype wire

// ===== src/pckp_chan_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pckp_chan_if: valid/ready channel
// Generic handshake channel carrying one payload of a given type.
// ----------------------------------------------------------------------------
interface pckp_chan_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

// ===== src/pckp_key_decode.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// pckp_key_decode: keypad row decode
// Pick the lowest active row and map it with the driven column to a key code.
// ----------------------------------------------------------------------------
module pckp_key_decode
   import pckp_pkg::*;
(
   input  wire logic [3:0] rows,
   input  wire logic [1:0] column,
   output key_type         key
);

   logic [1:0] row_sel;

   // lowest set row wins
   always_comb begin
      row_sel = 2'd0;
      case (1'b1)
         rows[0]: row_sel = 2'd0;
         rows[1]: row_sel = 2'd1;
         rows[2]: row_sel = 2'd2;
         rows[3]: row_sel = 2'd3;
         default: row_sel = 2'd0;
      endcase
   end

   assign key.hit  = |rows;
   assign key.code = (|rows) ? key_lookup(row_sel, column) : KeyNone;

endmodule
`default_nettype wire

// ===== src/people_counter_keypad_preset.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// people_counter_keypad_preset: bidirectional people counter, keypad preset
// Count light-barrier crossings into a signed occupancy and let a scanned
// 3x4 keypad type and load a new count.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                     handshake
//  req_chan  in   sensor_a, sensor_b, key_rows                valid/ready
//  rsp_chan  out  column_drive, occupancy, entry_mode,        valid/ready
//                 entry_value, send_request
//  csr_chan  in   debounce_reload (5 bits)                    valid/ready
//
//  One request is one timer tick and gives exactly one response, in the
//  cycle after acceptance. A request is taken every cycle while the response
//  register is empty or being drained; the single output register sets
//  the rate at one request per cycle.
//  reset (synchronous) clears all counter and keypad state, loads the
//  lockout and debounce_reload with 20 and empties the response register.
//  A stalled response holds and blocks new requests until it is taken.
//  csr_chan is always ready.
// ----------------------------------------------------------------------------
module people_counter_keypad_preset
   import pckp_pkg::*;
#(
   parameter int unsigned MAX_DIGITS = 9
) (
   input wire logic clock,
   input wire logic reset,
   pckp_chan_if.sink   req_chan,
   pckp_chan_if.source rsp_chan,
   pckp_chan_if.sink   csr_chan
);

   localparam int unsigned PosWidth = $clog2(MAX_DIGITS + 1);
   localparam logic [PosWidth-1:0] PosLimit = PosWidth'(MAX_DIGITS);

   // configuration
   reload_type reload_ff;

   // sensor state
   logic prev_a_ff;
   logic prev_b_ff;
   logic half_ff, half_in;
   logic [CountWidth-1:0] count_ff, count_in;

   // keypad state
   logic [1:0]            column_ff, column_in;
   reload_type            lockout_ff, lockout_in;
   logic                  entry_ff, entry_in;
   logic [EntryWidth-1:0] typed_ff, typed_in;
   logic [PosWidth-1:0]   pos_ff, pos_in;

   // response register
   logic    rsp_valid_ff;
   rsp_type rsp_ff, rsp_in;

   logic    req_fire;
   logic    send;
   logic    key_take;
   logic [3:0] digit;
   logic [EntryWidth-1:0] typed_times10;
   key_type key;

   // take a new tick when the response slot is free or draining
   assign req_chan.ready   = !rsp_valid_ff || rsp_chan.ready;
   assign req_fire         = req_chan.valid && req_chan.ready;
   assign csr_chan.ready   = 1'b1;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_ff;

   // advance the column scan before reading the rows
   assign column_in = (column_ff >= LastColumn) ? 2'd0 : column_ff + 2'd1;

   pckp_key_decode u_key_decode (
      .rows   (req_chan.payload.key_rows),
      .column (column_in),
      .key    (key)
   );

   assign key_take      = (lockout_ff == '0) && key.hit;
   assign digit         = key.code;
   assign typed_times10 = (typed_ff << 3) + (typed_ff << 1);

   always_comb begin
      half_in    = half_ff;
      count_in   = count_ff;
      send       = 1'b0;
      entry_in   = entry_ff;
      typed_in   = typed_ff;
      pos_in     = pos_ff;
      lockout_in = lockout_ff;

      // sensor path: a lone barrier change is a half crossing; the second
      // one completes the crossing and steps the count
      if ((req_chan.payload.sensor_a != prev_a_ff || req_chan.payload.sensor_b != prev_b_ff)
          && (req_chan.payload.sensor_a != req_chan.payload.sensor_b)) begin
         if (half_ff) begin
            count_in = req_chan.payload.sensor_a ? count_ff - 1'b1 : count_ff + 1'b1;
            send     = 1'b1;
            half_in  = 1'b0;
         end else begin
            half_in = 1'b1;
         end
      end

      // keypad path; a star load overrides a sensor step in the same tick
      if (key_take) begin
         lockout_in = reload_ff;
         case (key.code)
            KeyHash: begin
               entry_in = 1'b1;
               pos_in   = '0;
            end
            KeyStar: begin
               entry_in = 1'b0;
               count_in = CountWidth'(typed_ff);
               send     = 1'b1;
            end
            default: begin
               // drop digits past the limit
               if (pos_ff < PosLimit) begin
                  typed_in = (pos_ff == '0) ? EntryWidth'(digit)
                                            : typed_times10 + EntryWidth'(digit);
                  pos_in   = pos_ff + 1'b1;
               end
            end
         endcase
      end
      // count the lockout down, including the tick a key was taken
      if (lockout_in != '0) begin
         lockout_in = lockout_in - 1'b1;
      end

      rsp_in.column_drive = 3'(3'b001 << column_in);
      rsp_in.occupancy    = count_in;
      rsp_in.entry_mode   = entry_in;
      rsp_in.entry_value  = typed_in;
      rsp_in.send_request = send;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reload_ff    <= LockoutReset;
         prev_a_ff    <= 1'b0;
         prev_b_ff    <= 1'b0;
         half_ff      <= 1'b0;
         count_ff     <= '0;
         column_ff    <= 2'd0;
         lockout_ff   <= LockoutReset;
         entry_ff     <= 1'b0;
         typed_ff     <= '0;
         pos_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_chan.valid) begin
            reload_ff <= csr_chan.payload;
         end
         if (req_fire) begin
            prev_a_ff    <= req_chan.payload.sensor_a;
            prev_b_ff    <= req_chan.payload.sensor_b;
            half_ff      <= half_in;
            count_ff     <= count_in;
            column_ff    <= column_in;
            lockout_ff   <= lockout_in;
            entry_ff     <= entry_in;
            typed_ff     <= typed_in;
            pos_ff       <= pos_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // hold the response payload until a new request replaces it
   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule
`default_nettype wire
